// ===== design/fdac_pkg.sv =====
`timescale 1ns / 1ps

package fdac_pkg;

  localparam int BYTE_W      = 8;
  localparam int SYNC_W      = 16;
  localparam int CMD_W       = 32;
  localparam int LEN_W       = 16;
  localparam int PLEN_W      = 7;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [SYNC_W-1:0] SYNC_RESET = 16'hBB00;

  // byte counts of the header fields, as the last count value of each
  localparam logic [CNT_W-1:0] CMD_LAST = CNT_W'(4 - 1);
  localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(2 - 1);

  typedef struct packed {
    logic sync_start;
    logic shift_cmd;
    logic shift_len;
    logic store_data;
    logic cnt_clr;
    logic cnt_inc;
    logic ram_rd;
    logic out_load;
  } fdac_cmd_t;

  typedef struct packed {
    logic hi_match;
    logic lo_match;
    logic cmd_last;
    logic len_last;
    logic len_over;
    logic len_zero;
    logic cnt_reach;
    logic sum_ok;
    logic out_free;
  } fdac_stat_t;

endpackage

// ===== design/fdac_ifs.sv =====
`timescale 1ns / 1ps

interface fdac_in_if;
  logic                         valid;
  logic                         ready;
  logic [fdac_pkg::BYTE_W-1:0]  rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fdac_out_if;
  logic                         valid;
  logic                         ready;
  logic [fdac_pkg::CMD_W-1:0]   frame_cmd;
  logic [fdac_pkg::PLEN_W-1:0]  payload_len;
  logic                         has_data;
  logic [fdac_pkg::BYTE_W-1:0]  data_byte;
  logic [fdac_pkg::IDX_W-1:0]   byte_index;
  logic                         last;
  modport source (output valid, output frame_cmd, output payload_len, output has_data,
                  output data_byte, output byte_index, output last, input ready);
  modport sink   (input valid, input frame_cmd, input payload_len, input has_data,
                  input data_byte, input byte_index, input last, output ready);
endinterface

interface fdac_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fdac_pkg::SYNC_W-1:0]  sync_word;
  modport source (output valid, output sync_word, input ready);
  modport sink   (input valid, input sync_word, output ready);
endinterface

// ===== design/fdac_ram.sv =====
`timescale 1ns / 1ps

module fdac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/fdac_ctrl.sv =====
`timescale 1ns / 1ps

module fdac_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fdac_pkg::fdac_stat_t stat,
  output fdac_pkg::fdac_cmd_t  cmd
);
  import fdac_pkg::*;

  typedef enum logic [3:0] {
    ST_HUNT_HI,
    ST_HUNT_LO,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_PAD,
    ST_DR_READ,
    ST_DR_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   fire;

  assign fire     = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT_HI: begin
        if (fire && stat.hi_match) state_nxt = ST_HUNT_LO;
      end
      ST_HUNT_LO: begin
        if (fire) begin
          if (stat.lo_match) begin
            cmd.sync_start = 1'b1;
            cmd.cnt_clr    = 1'b1;
            state_nxt      = ST_CMD;
          end else if (!stat.hi_match) begin
            state_nxt = ST_HUNT_HI;
          end
        end
      end
      ST_CMD: begin
        if (fire) begin
          cmd.shift_cmd = 1'b1;
          if (stat.cmd_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_LEN;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (fire) begin
          cmd.shift_len = 1'b1;
          if (stat.len_last) begin
            cmd.cnt_clr = 1'b1;
            if (stat.len_over)      state_nxt = ST_HUNT_HI;
            else if (stat.len_zero) state_nxt = ST_CHECK;
            else                    state_nxt = ST_DATA;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (fire) begin
          cmd.store_data = 1'b1;
          cmd.cnt_inc    = 1'b1;
          if (stat.cnt_reach) state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fire) state_nxt = stat.sum_ok ? ST_PAD : ST_HUNT_HI;
      end
      ST_PAD: begin
        if (fire) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_DR_READ;
        end
      end
      ST_DR_READ: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = ST_DR_LOAD;
      end
      ST_DR_LOAD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_nxt    = stat.cnt_reach ? ST_HUNT_HI : ST_DR_READ;
        end
      end
      default: state_nxt = ST_HUNT_HI;
    endcase
  end

  // no byte is taken while the buffered payload drains
  assign in_ready_nxt = !(state_nxt inside {ST_DR_READ, ST_DR_LOAD});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HUNT_HI;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded into an occupied output slot");

  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_rd |=> (state_r == ST_DR_LOAD))
    else $error("payload read not followed by load");

  a_last_reopens_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && stat.cnt_reach) |=> in_ready)
    else $error("input not reopened after final result");

  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ram_rd || cmd.out_load) |-> !fire)
    else $error("byte transfer during payload drain");

endmodule

// ===== design/fdac_dpath.sv =====
`timescale 1ns / 1ps

module fdac_dpath #(
  parameter int MAX_PAYLOAD = fdac_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fdac_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          cfg_valid,
  input  logic [fdac_pkg::SYNC_W-1:0]   cfg_sync_word,
  input  fdac_pkg::fdac_cmd_t           cmd,
  output fdac_pkg::fdac_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdac_pkg::CMD_W-1:0]    out_frame_cmd,
  output logic [fdac_pkg::PLEN_W-1:0]   out_payload_len,
  output logic                          out_has_data,
  output logic [fdac_pkg::BYTE_W-1:0]   out_data_byte,
  output logic [fdac_pkg::IDX_W-1:0]    out_byte_index,
  output logic                          out_last
);
  import fdac_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [SYNC_W-1:0] sync_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] sum_r;
  logic [CNT_W-1:0]  count_r;
  logic [LEN_W-1:0]  len_new;
  logic [LEN_W-1:0]  count_inc;
  logic [BYTE_W-1:0] ram_q;
  logic              has_data;

  logic              out_valid_r;
  logic [CMD_W-1:0]  out_cmd_r;
  logic [PLEN_W-1:0] out_len_r;
  logic              out_has_r;
  logic [BYTE_W-1:0] out_data_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  assign len_new   = {len_r[BYTE_W-1:0], rx_byte};
  assign count_inc = LEN_W'(count_r) + LEN_W'(1);
  assign has_data  = (len_r != '0);

  assign stat.hi_match  = (rx_byte == sync_r[SYNC_W-1:BYTE_W]);
  assign stat.lo_match  = (rx_byte == sync_r[BYTE_W-1:0]);
  assign stat.cmd_last  = (count_r == CMD_LAST);
  assign stat.len_last  = (count_r == LEN_LAST);
  assign stat.len_over  = (len_new > LEN_W'(MAX_PAYLOAD));
  assign stat.len_zero  = (len_new == '0);
  // also true at once for an empty payload
  assign stat.cnt_reach = (count_inc >= len_r);
  assign stat.sum_ok    = (rx_byte == sum_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= SYNC_RESET;
      cmd_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      if (cfg_valid) sync_r <= cfg_sync_word;
      if (cmd.sync_start) begin
        cmd_r <= '0;
        len_r <= '0;
        sum_r <= sync_r[SYNC_W-1:BYTE_W] + sync_r[BYTE_W-1:0];
      end
      if (cmd.shift_cmd) cmd_r <= {cmd_r[CMD_W-BYTE_W-1:0], rx_byte};
      if (cmd.shift_len) len_r <= len_new;
      if (cmd.shift_cmd || cmd.shift_len || cmd.store_data) sum_r <= sum_r + rx_byte;
      if (cmd.cnt_clr)      count_r <= '0;
      else if (cmd.cnt_inc) count_r <= count_r + CNT_W'(1);
    end
  end

  fdac_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store_data),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.ram_rd),
    .rd_addr (count_r[AW-1:0]),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r[PLEN_W-1:0];
      out_has_r  <= has_data;
      out_data_r <= has_data ? ram_q : '0;
      out_idx_r  <= count_r[IDX_W-1:0];
      out_last_r <= stat.cnt_reach;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_cmd   = out_cmd_r;
  assign out_payload_len = out_len_r;
  assign out_has_data    = out_has_r;
  assign out_data_byte   = out_data_r;
  assign out_byte_index  = out_idx_r;
  assign out_last        = out_last_r;

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_data |-> (int'(count_r) < MAX_PAYLOAD))
    else $error("payload write beyond store depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> out_last_r)
    else $error("empty-payload result not marked last");

endmodule

// ===== design/frame_deframer_additive_checksum.sv =====
// channel  dir  payload                                                  transfer
// in_ch    in   rx_byte[7:0]                                             valid & ready
// out_ch   out  frame_cmd, payload_len, has_data, data_byte, byte_index, last
//                                                                        valid & ready
// cfg_ch   in   sync_word[15:0]                                          valid & ready
//
// one received byte per cycle while framing; ready is high outside the payload drain
// a good frame gives len results (one for an empty payload) after its pad byte, each
// through the registered payload ram read and then the load, which waits while out_ch stalls
// input reopens once the final result sits in the output register
// rst_n is synchronous; cfg writes are always taken and apply at the next sync compare
`timescale 1ns / 1ps

module frame_deframer_additive_checksum #(
  parameter int MAX_PAYLOAD = fdac_pkg::MAX_PAYLOAD_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fdac_in_if.sink    in_ch,
  fdac_out_if.source out_ch,
  fdac_cfg_if.sink   cfg_ch
);
  import fdac_pkg::*;

  fdac_cmd_t  cmd;
  fdac_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  fdac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fdac_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_byte         (in_ch.rx_byte),
    .cfg_valid       (cfg_ch.valid),
    .cfg_sync_word   (cfg_ch.sync_word),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_frame_cmd   (out_ch.frame_cmd),
    .out_payload_len (out_ch.payload_len),
    .out_has_data    (out_ch.has_data),
    .out_data_byte   (out_ch.data_byte),
    .out_byte_index  (out_ch.byte_index),
    .out_last        (out_ch.last)
  );

endmodule
